>>> rtl/rrp_pkg.sv
// shared types and constants for the resp request parser
package rrp_pkg;

   localparam int unsigned MAX_REQUEST_BYTES = 1048576;
   localparam int unsigned MAX_ARGS          = 1024;
   localparam int unsigned NUM_CAP  = (MAX_REQUEST_BYTES > MAX_ARGS) ? MAX_REQUEST_BYTES
                                                                     : MAX_ARGS;
   localparam int unsigned CNT_SAT  = MAX_REQUEST_BYTES + 1;

   // widths fixed by the result fields
   localparam int unsigned KIND_W = 2;
   localparam int unsigned IDX_W  = 10;
   localparam int unsigned LEN_W  = 21;
   localparam int unsigned ERR_W  = 3;

   // internal widths
   localparam int unsigned MAG_W  = $clog2(NUM_CAP + 1);
   localparam int unsigned CNT_W  = $clog2(CNT_SAT + 1);
   localparam int unsigned ARGS_W = $clog2(MAX_ARGS + 1);
   localparam int unsigned SUM_W  = ((CNT_W > MAG_W) ? CNT_W : MAG_W) + 1;

   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_CNT    = 4'd1,
      PH_CNT_LF = 4'd2,
      PH_MARK   = 4'd3,
      PH_LEN    = 4'd4,
      PH_LEN_LF = 4'd5,
      PH_PAY    = 4'd6,
      PH_PAY_CR = 4'd7,
      PH_PAY_LF = 4'd8,
      PH_ERR    = 4'd9
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ARG_END = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NO_ARRAY  = 3'd0,
      ERR_BAD_COUNT = 3'd1,
      ERR_NO_BULK   = 3'd2,
      ERR_BAD_LEN   = 3'd3,
      ERR_NO_CRLF   = 3'd4,
      ERR_TOO_LARGE = 3'd5
   } err_type;

   typedef struct packed {
      logic             negative;
      logic [MAG_W-1:0] magnitude;
      logic             overflow;
      logic             bad;
      logic             empty;
   } num_line_type;

   localparam num_line_type LINE_START = '{negative: 1'b0, magnitude: '0,
                                           overflow: 1'b0, bad: 1'b0, empty: 1'b1};

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       payload_byte;
      logic [IDX_W-1:0] arg_index;
      logic [LEN_W-1:0] arg_length;
      logic             request_done;
      logic [LEN_W-1:0] consumed;
      err_type          error_code;
   } rsp_item_type;

endpackage

>>> rtl/resp_request_parser_top.sv
// path: an accepted request byte passes the input register, the parser step and then the result register
// throughput: one request byte per cycle while no stalled result holds the flow, set by the parser step
// between the input register and the result register
// a stalled result holds the parser step, and the input register then stalls the sender
// reset (synchronous, active high) empties both registers and returns the parser to idle
module resp_request_parser_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_clear,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [rrp_pkg::KIND_W-1:0] rsp_kind,
   output logic [7:0]                rsp_payload_byte,
   output logic [rrp_pkg::IDX_W-1:0] rsp_arg_index,
   output logic [rrp_pkg::LEN_W-1:0] rsp_arg_length,
   output logic                      rsp_request_done,
   output logic [rrp_pkg::LEN_W-1:0] rsp_consumed,
   output logic [rrp_pkg::ERR_W-1:0] rsp_error_code
);
   import rrp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_clear_ff;
   logic         accept, advance, free;
   logic         res_valid;
   rsp_item_type res, rsp_item;

   assign advance   = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_rx_byte;
         in_clear_ff <= req_clear;
      end
   end

   rrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .clear     (in_clear_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   rrp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .item      (res),
      .rsp_stall (rsp_stall),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind         = rsp_item.kind;
   assign rsp_payload_byte = rsp_item.payload_byte;
   assign rsp_arg_index    = rsp_item.arg_index;
   assign rsp_arg_length   = rsp_item.arg_length;
   assign rsp_request_done = rsp_item.request_done;
   assign rsp_consumed     = rsp_item.consumed;
   assign rsp_error_code   = rsp_item.error_code;

endmodule

>>> rtl/rrp_parser.sv
// parser state registers and the per-byte next-state and result logic
module rrp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic                 clear,
   output logic                 res_valid,
   output rrp_pkg::rsp_item_type res
);
   import rrp_pkg::*;

   localparam logic [MAG_W-1:0] NUM_CAP_M   = MAG_W'(NUM_CAP);
   localparam logic [MAG_W-1:0] MAX_ARGS_M  = MAG_W'(MAX_ARGS);
   localparam logic [MAG_W-1:0] MAX_REQ_M   = MAG_W'(MAX_REQUEST_BYTES);
   localparam logic [CNT_W-1:0] CNT_SAT_C   = CNT_W'(CNT_SAT);
   localparam logic [SUM_W-1:0] MAX_REQ_S   = SUM_W'(MAX_REQUEST_BYTES);

   phase_type        phase_ff, phase_in;
   num_line_type     line_ff, line_in;
   logic [ARGS_W-1:0] args_left_ff, args_left_in;
   logic [IDX_W-1:0] current_arg_ff, current_arg_in;
   logic [LEN_W-1:0] payload_left_ff, payload_left_in;
   logic [LEN_W-1:0] arg_len_held_ff, arg_len_held_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;

   // one non-cr character into the number line
   function automatic num_line_type line_char(num_line_type cur, logic [7:0] b);
      num_line_type   nxt;
      logic [MAG_W+3:0] m;
      nxt = cur;
      m   = '0;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         nxt.empty = 1'b0;
         if (!cur.overflow) begin
            m = (MAG_W+4)'({cur.magnitude, 3'b000}) + (MAG_W+4)'({cur.magnitude, 1'b0})
                + (MAG_W+4)'(b - CH_ZERO);
            if (m > (MAG_W+4)'(NUM_CAP_M)) begin
               nxt.overflow  = 1'b1;
               nxt.magnitude = NUM_CAP_M;
            end else begin
               nxt.magnitude = m[MAG_W-1:0];
            end
         end
      end else if (b == CH_MINUS && cur.empty && !cur.negative && !cur.bad) begin
         nxt.negative = 1'b1;
      end else begin
         nxt.bad = 1'b1;
      end
      return nxt;
   endfunction

   logic [CNT_W-1:0]  bc_inc;
   logic              line_ok;
   num_line_type      line_tmp;
   logic [SUM_W-1:0]  total;
   logic [LEN_W-1:0]  pl_dec;
   logic [ARGS_W-1:0] al_dec;

   always_comb begin
      bc_inc   = (byte_count_ff < CNT_SAT_C) ? byte_count_ff + 1'b1 : byte_count_ff;
      line_ok  = !line_ff.bad && !line_ff.empty && !line_ff.overflow;
      total    = SUM_W'(bc_inc) + SUM_W'(line_ff.magnitude) + SUM_W'(2);
      pl_dec   = (payload_left_ff != '0) ? payload_left_ff - 1'b1 : payload_left_ff;
      al_dec   = (args_left_ff != '0) ? args_left_ff - 1'b1 : args_left_ff;
      line_tmp = line_ff;

      phase_in        = phase_ff;
      line_in         = line_ff;
      args_left_in    = args_left_ff;
      current_arg_in  = current_arg_ff;
      payload_left_in = payload_left_ff;
      arg_len_held_in = arg_len_held_ff;
      byte_count_in   = byte_count_ff;

      res_valid      = 1'b0;
      res            = '0;
      res.arg_index  = current_arg_ff;

      if (clear) begin
         phase_in        = PH_IDLE;
         line_in         = LINE_START;
         args_left_in    = '0;
         current_arg_in  = '0;
         payload_left_in = '0;
         arg_len_held_in = '0;
         byte_count_in   = '0;
      end else begin
         unique case (phase_ff) inside
            PH_IDLE: begin
               line_in         = LINE_START;
               args_left_in    = '0;
               current_arg_in  = '0;
               payload_left_in = '0;
               arg_len_held_in = '0;
               byte_count_in   = '0;
               if (rx_byte != CH_STAR) begin
                  phase_in       = PH_ERR;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.arg_index  = '0;
                  res.error_code = ERR_NO_ARRAY;
               end else begin
                  byte_count_in = CNT_W'(1);
                  phase_in      = PH_CNT;
               end
            end
            PH_CNT, PH_LEN: begin
               byte_count_in = bc_inc;
               if (rx_byte == CH_CR) begin
                  phase_in = (phase_ff == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
               end else begin
                  line_in = line_char(line_ff, rx_byte);
               end
            end
            PH_CNT_LF, PH_LEN_LF: begin
               byte_count_in = bc_inc;
               if (rx_byte != CH_LF) begin
                  line_tmp.bad = 1'b1;
                  // a stray character resumes the line, a second cr keeps waiting
                  if (rx_byte != CH_CR) begin
                     line_tmp = line_char(line_tmp, rx_byte);
                     phase_in = (phase_ff == PH_CNT_LF) ? PH_CNT : PH_LEN;
                  end
                  line_in = line_tmp;
               end else if (phase_ff == PH_CNT_LF) begin
                  if (!line_ok || line_ff.negative || line_ff.magnitude == '0
                      || line_ff.magnitude > MAX_ARGS_M) begin
                     phase_in       = PH_ERR;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_BAD_COUNT;
                  end else if (SUM_W'(bc_inc) > MAX_REQ_S) begin
                     phase_in       = PH_ERR;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_TOO_LARGE;
                  end else begin
                     args_left_in   = ARGS_W'(line_ff.magnitude);
                     current_arg_in = '0;
                     phase_in       = PH_MARK;
                  end
               end else begin
                  // minus zero is a valid empty length
                  if (!line_ok || (line_ff.negative && line_ff.magnitude != '0)
                      || line_ff.magnitude > MAX_REQ_M) begin
                     phase_in       = PH_ERR;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_BAD_LEN;
                  end else if (total > MAX_REQ_S) begin
                     phase_in       = PH_ERR;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_TOO_LARGE;
                  end else begin
                     payload_left_in = LEN_W'(line_ff.magnitude);
                     arg_len_held_in = LEN_W'(line_ff.magnitude);
                     phase_in = (line_ff.magnitude == '0) ? PH_PAY_CR : PH_PAY;
                  end
               end
            end
            PH_MARK: begin
               byte_count_in = bc_inc;
               if (rx_byte != CH_DOLLAR) begin
                  phase_in       = PH_ERR;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NO_BULK;
               end else begin
                  line_in  = LINE_START;
                  phase_in = PH_LEN;
               end
            end
            PH_PAY: begin
               byte_count_in   = bc_inc;
               payload_left_in = pl_dec;
               if (pl_dec == '0) begin
                  phase_in = PH_PAY_CR;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = rx_byte;
            end
            PH_PAY_CR: begin
               byte_count_in = bc_inc;
               line_in.bad   = (rx_byte != CH_CR);
               phase_in      = PH_PAY_LF;
            end
            PH_PAY_LF: begin
               byte_count_in = bc_inc;
               if (line_ff.bad || rx_byte != CH_LF) begin
                  phase_in       = PH_ERR;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NO_CRLF;
               end else begin
                  res_valid      = 1'b1;
                  res.kind       = KIND_ARG_END;
                  res.arg_length = arg_len_held_ff;
                  if (al_dec == '0) begin
                     res.request_done = 1'b1;
                     res.consumed     = LEN_W'(bc_inc);
                     phase_in         = PH_IDLE;
                     line_in          = LINE_START;
                     args_left_in     = '0;
                     current_arg_in   = '0;
                     payload_left_in  = '0;
                     arg_len_held_in  = '0;
                     byte_count_in    = '0;
                  end else begin
                     args_left_in   = al_dec;
                     current_arg_in = current_arg_ff + 1'b1;
                     phase_in       = PH_MARK;
                  end
               end
            end
            default: begin
               // error phase: bytes are dropped until clear
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         line_ff         <= LINE_START;
         args_left_ff    <= '0;
         current_arg_ff  <= '0;
         payload_left_ff <= '0;
         arg_len_held_ff <= '0;
         byte_count_ff   <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         line_ff         <= line_in;
         args_left_ff    <= args_left_in;
         current_arg_ff  <= current_arg_in;
         payload_left_ff <= payload_left_in;
         arg_len_held_ff <= arg_len_held_in;
         byte_count_ff   <= byte_count_in;
      end
   end

endmodule

>>> rtl/rrp_out_reg.sv
// result register holding one response item until the consumer takes it
module rrp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rrp_pkg::rsp_item_type item,
   input  logic                  rsp_stall,
   output logic                  free,
   output logic                  rsp_valid,
   output rrp_pkg::rsp_item_type rsp_item
);
   import rrp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // slot can take a new item when empty or being drained this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
